### src/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

	localparam int PACKED_BYTES = 48;
	localparam int PB_AW        = $clog2(PACKED_BYTES);
	localparam int PB_CW        = $clog2(PACKED_BYTES + 1);
	localparam int VARINT_MAX   = 10;
	localparam int VLEN_W       = $clog2(VARINT_MAX + 1);

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	typedef enum logic [2:0] {
		MODE_VARINT  = 3'd0,
		MODE_LENHDR  = 3'd1,
		MODE_PAYLOAD = 3'd2,
		MODE_PACKED  = 3'd3,
		MODE_CLOSE   = 3'd4
	} pfe_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAG,
		ST_VAL,
		ST_PAY,
		ST_APPEND,
		ST_PKLEN,
		ST_PKDATA,
		ST_ERR
	} pfe_state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [28:0] field_number;
		logic [63:0] value;
	} pfe_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} pfe_out_t;

	typedef struct packed {
		logic     vld;
		pfe_out_t data;
	} pfe_emit_t;

	typedef struct packed {
		logic        load;
		logic        shift;
		logic [63:0] data;
	} pfe_vctl_t;

	typedef struct packed {
		logic [6:0] digit;
		logic       more;
		logic [7:0] low;
	} pfe_vsts_t;

	typedef struct packed {
		logic             we;
		logic [PB_AW-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PB_AW-1:0] raddr;
	} pfe_ram_t;

	typedef struct packed {
		logic             busy;
		logic [PB_CW-1:0] fill;
		logic             ovf;
	} pfe_sts_t;

	// Number of base-128 digits needed for v (1 to 10).
	function automatic logic [VLEN_W-1:0] varint_len(logic [63:0] v);
		logic [VLEN_W-1:0] n;
		n = VLEN_W'(1);
		for (int g = 1; g < VARINT_MAX; g++) begin
			if ((v >> (7 * g)) != 64'd0) begin
				n = VLEN_W'(g + 1);
			end
		end
		return n;
	endfunction

endpackage

### src/protobuf_field_emitter.sv
`timescale 1ns / 1ps
// Serializes protocol-buffer fields into a wire byte stream.
// Input channel (item_valid / item_stall / item): one field command per
// transaction, selected by mode: varint field, length header, payload byte,
// packed element, packed close. Output channel (enc_valid / enc_stall / enc):
// one wire byte per transaction, last on the final byte of a command, error
// on the single byte of a packed close whose buffer overflowed.
// Commands are handled one at a time; item_stall stays high while one runs.
// Once a command is taken, the sequencer state and then the output register
// lie before its first byte; bytes then follow one per cycle while the output
// is not stalled, varint digits shifted out 7 bits a step by the varint
// shift register. A packed close with data waits on the first buffer read
// before its data bytes; a packed element is written through the buffer
// write port, one byte a cycle; a dropped element or an unused mode emits no byte.
// A stall on the output holds the byte in the output register and freezes
// the sequencer's byte-emitting states; nothing is lost or repeated.
// Reset clears the fill count and the overflow flag; the packed buffer
// contents need no clearing, since only written bytes are ever read back.
module protobuf_field_emitter
	import pfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  pfe_item_t item,
	output logic      enc_valid,
	input  logic      enc_stall,
	output pfe_out_t  enc
);

	pfe_emit_t  emit;
	pfe_vctl_t  vctl;
	pfe_vsts_t  vsts;
	pfe_ram_t   ram;
	pfe_sts_t   sts;
	logic [7:0] rdata;
	logic       advance;
	logic       enc_valid_q;
	pfe_out_t   enc_q;

	pfe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.emit       (emit),
		.vctl       (vctl),
		.vsts       (vsts),
		.ram        (ram),
		.rdata      (rdata),
		.sts        (sts)
	);

	pfe_varint u_varint (
		.clk (clk),
		.ctl (vctl),
		.sts (vsts)
	);

	pfe_ram #(
		.WIDTH (8),
		.DEPTH (PACKED_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	// Advance when the output register is empty or being drained.
	assign advance = !enc_valid_q || !enc_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_valid_q <= 1'b0;
		end else if (advance) begin
			enc_valid_q <= emit.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit.vld) begin
			enc_q <= emit.data;
		end
	end

	assign item_stall = sts.busy;
	assign enc_valid  = enc_valid_q;
	assign enc        = enc_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.fill <= PB_CW'(PACKED_BYTES))
		else $error("packed fill beyond buffer size");

	a_ovf_near_full: assert property (@(posedge clk) disable iff (!arst_n)
		sts.ovf |-> (int'(sts.fill) + VARINT_MAX > PACKED_BYTES))
		else $error("overflow flagged while an element would still fit");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		(enc_valid && enc.error) |-> (enc.last && enc.out_byte == 8'd0))
		else $error("error byte malformed");

	a_busy_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.busy |-> !emit.vld)
		else $error("idle sequencer emits a byte");

endmodule

### src/pfe_ram.sv
`timescale 1ns / 1ps

module pfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/pfe_varint.sv
`timescale 1ns / 1ps

module pfe_varint
	import pfe_pkg::*;
(
	input  logic      clk,
	input  pfe_vctl_t ctl,
	output pfe_vsts_t sts
);

	logic [63:0] sr_q;

	// Shift out one 7-bit digit per step, least significant first.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sr_q <= ctl.data;
		end else if (ctl.shift) begin
			sr_q <= {7'd0, sr_q[63:7]};
		end
	end

	assign sts.digit = sr_q[6:0];
	assign sts.more  = |sr_q[63:7];
	assign sts.low   = sr_q[7:0];

endmodule

### src/pfe_seq.sv
`timescale 1ns / 1ps

module pfe_seq
	import pfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  pfe_item_t  item,
	input  logic       advance,
	output pfe_emit_t  emit,
	output pfe_vctl_t  vctl,
	input  pfe_vsts_t  vsts,
	output pfe_ram_t   ram,
	input  logic [7:0] rdata,
	output pfe_sts_t   sts
);

	pfe_state_t       state_q, state_d;
	logic [63:0]      value_q;
	logic             close_q;
	logic [PB_CW-1:0] fill_q, ptr_q;
	logic             ovf_q, rvalid_q;
	logic             accept, fits, last_pk;
	logic [PB_CW:0]   need;
	logic             pk_clr, ovf_set, fill_inc, ptr_inc, consume;
	logic [2:0]       wt;

	assign accept  = item_valid && (state_q == ST_IDLE);
	assign need    = {1'b0, fill_q} + (PB_CW + 1)'(varint_len(item.value));
	assign fits    = need <= (PB_CW + 1)'(PACKED_BYTES);
	assign last_pk = (ptr_q == fill_q);
	assign consume = (state_q == ST_PKDATA) && advance && rvalid_q;
	assign wt      = (pfe_mode_t'(item.mode) == MODE_VARINT) ? WT_VARINT : WT_LEN;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (pfe_mode_t'(item.mode))
						MODE_VARINT, MODE_LENHDR: state_d = ST_TAG;
						MODE_PAYLOAD:             state_d = ST_PAY;
						MODE_PACKED: begin
							if (!ovf_q && fits) begin
								state_d = ST_APPEND;
							end
						end
						MODE_CLOSE:               state_d = ovf_q ? ST_ERR : ST_TAG;
						default:                  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TAG: begin
				if (advance && !vsts.more) begin
					state_d = close_q ? ST_PKLEN : ST_VAL;
				end
			end
			ST_VAL: begin
				if (advance && !vsts.more) begin
					state_d = ST_IDLE;
				end
			end
			ST_PAY: begin
				if (advance) begin
					state_d = ST_IDLE;
				end
			end
			ST_APPEND: begin
				if (!vsts.more) begin
					state_d = ST_IDLE;
				end
			end
			ST_PKLEN: begin
				if (advance && !vsts.more) begin
					state_d = (fill_q == '0) ? ST_IDLE : ST_PKDATA;
				end
			end
			ST_PKDATA: begin
				if (consume && last_pk) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (advance) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = '0;
		vctl      = '0;
		ram       = '0;
		pk_clr    = 1'b0;
		ovf_set   = 1'b0;
		fill_inc  = 1'b0;
		ptr_inc   = 1'b0;
		ram.waddr = fill_q[PB_AW-1:0];
		ram.raddr = ptr_q[PB_AW-1:0];
		ram.wdata = {vsts.more, vsts.digit};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vctl.load = 1'b1;
					if (pfe_mode_t'(item.mode) == MODE_PAYLOAD ||
					    pfe_mode_t'(item.mode) == MODE_PACKED) begin
						vctl.data = item.value;
					end else begin
						vctl.data = {32'd0, item.field_number, wt};
					end
					// Drop the element and flag the buffer when it does not fit whole.
					if (pfe_mode_t'(item.mode) == MODE_PACKED && !ovf_q && !fits) begin
						ovf_set = 1'b1;
					end
				end
			end
			ST_TAG: begin
				emit.vld           = 1'b1;
				emit.data.out_byte = {vsts.more, vsts.digit};
				if (advance) begin
					if (vsts.more) begin
						vctl.shift = 1'b1;
					end else begin
						vctl.load = 1'b1;
						vctl.data = close_q ? 64'(fill_q) : value_q;
					end
				end
			end
			ST_VAL: begin
				emit.vld           = 1'b1;
				emit.data.out_byte = {vsts.more, vsts.digit};
				emit.data.last     = !vsts.more;
				vctl.shift         = advance;
			end
			ST_PAY: begin
				emit.vld           = 1'b1;
				emit.data.out_byte = vsts.low;
				emit.data.last     = 1'b1;
			end
			ST_APPEND: begin
				ram.we     = 1'b1;
				fill_inc   = 1'b1;
				vctl.shift = 1'b1;
			end
			ST_PKLEN: begin
				emit.vld           = 1'b1;
				emit.data.out_byte = {vsts.more, vsts.digit};
				emit.data.last     = !vsts.more && (fill_q == '0);
				vctl.shift         = advance;
				pk_clr             = advance && !vsts.more && (fill_q == '0);
			end
			ST_PKDATA: begin
				emit.vld           = rvalid_q;
				emit.data.out_byte = rdata;
				emit.data.last     = last_pk;
				// Prefetch the next byte once the held one is gone or leaving.
				ram.re             = !last_pk && (!rvalid_q || advance);
				ptr_inc            = ram.re;
				pk_clr             = consume && last_pk;
			end
			ST_ERR: begin
				emit.vld        = 1'b1;
				emit.data.last  = 1'b1;
				emit.data.error = 1'b1;
				pk_clr          = advance;
			end
			default: begin
				emit = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			ptr_q    <= '0;
			rvalid_q <= 1'b0;
			close_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pk_clr) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				if (fill_inc) begin
					fill_q <= fill_q + PB_CW'(1);
				end
				if (ovf_set) begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q != ST_PKDATA) begin
				ptr_q    <= '0;
				rvalid_q <= 1'b0;
			end else begin
				if (ptr_inc) begin
					ptr_q <= ptr_q + PB_CW'(1);
				end
				if (ram.re) begin
					rvalid_q <= 1'b1;
				end else if (consume) begin
					rvalid_q <= 1'b0;
				end
			end
			if (accept) begin
				close_q <= (pfe_mode_t'(item.mode) == MODE_CLOSE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= item.value;
		end
	end

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.fill = fill_q;
	assign sts.ovf  = ovf_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

import pfe_pkg::*;

// Predicts the wire bytes of every accepted command and checks them in order.
class wire_byte_predictor;
	logic [7:0]  pack_mem [PACKED_BYTES];
	int unsigned pack_fill;
	bit          pack_ovf;
	logic [7:0]  staged[$];
	pfe_out_t    wire_bytes_due[$];
	int unsigned bytes_seen;
	int unsigned mismatches;

	function new();
		pack_fill = 0;
		pack_ovf = 1'b0;
		bytes_seen = 0;
		mismatches = 0;
	endfunction

	function void stage_varint(logic [63:0] v);
		while (v >= 64'h80) begin
			staged.insert(staged.size(), {1'b1, v[6:0]});
			v = v >> 7;
		end
		staged.insert(staged.size(), v[7:0]);
	endfunction

	function void stage_tag(logic [28:0] fnum, logic [2:0] wt);
		stage_varint({32'd0, fnum, wt});
	endfunction

	// Move the staged bytes to the expected stream; mark the final one.
	function void release_staged();
		pfe_out_t b;
		foreach (staged[k]) begin
			b.out_byte = staged[k];
			b.last = (k == staged.size() - 1);
			b.error = 1'b0;
			wire_bytes_due.insert(wire_bytes_due.size(), b);
		end
		staged.delete();
	endfunction

	function void take_command(pfe_item_t it);
		pfe_out_t b;
		case (it.mode)
			MODE_VARINT: begin
				stage_tag(it.field_number, WT_VARINT);
				stage_varint(it.value);
				release_staged();
			end
			MODE_LENHDR: begin
				stage_tag(it.field_number, WT_LEN);
				stage_varint(it.value);
				release_staged();
			end
			MODE_PAYLOAD: begin
				staged.insert(staged.size(), it.value[7:0]);
				release_staged();
			end
			MODE_PACKED: begin
				if (!pack_ovf) begin
					stage_varint(it.value);
					if (pack_fill + staged.size() > PACKED_BYTES) begin
						pack_ovf = 1'b1;
					end else begin
						foreach (staged[k]) begin
							pack_mem[pack_fill] = staged[k];
							pack_fill++;
						end
					end
					staged.delete();
				end
			end
			MODE_CLOSE: begin
				if (pack_ovf) begin
					b.out_byte = 8'd0;
					b.last = 1'b1;
					b.error = 1'b1;
					wire_bytes_due.insert(wire_bytes_due.size(), b);
				end else begin
					stage_tag(it.field_number, WT_LEN);
					stage_varint(64'(pack_fill));
					for (int k = 0; k < pack_fill; k++) begin
						staged.insert(staged.size(), pack_mem[k]);
					end
					release_staged();
				end
				pack_fill = 0;
				pack_ovf = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	task flag_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at byte %0d: %s", bytes_seen, msg);
	endtask

	task check_byte(pfe_out_t got);
		pfe_out_t want;
		bytes_seen++;
		if (wire_bytes_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected byte %h last %b error %b",
				got.out_byte, got.last, got.error));
		end else begin
			want = wire_bytes_due.pop_front();
			if (got.out_byte !== want.out_byte) begin
				flag_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
			end
			if (got.last !== want.last) begin
				flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
			end
			if (got.error !== want.error) begin
				flag_mismatch($sformatf("error %b, want %b", got.error, want.error));
			end
		end
	endtask

	function int unsigned pending();
		return wire_bytes_due.size();
	endfunction
endclass

module tb;
	localparam logic [2:0]  MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
	localparam int unsigned RAND_COMMANDS  = 180;
	localparam int unsigned PAUSE_AT       = 110;
	localparam int unsigned HOLD_AFTER     = 150;
	localparam int unsigned HOLD_CYCLES    = 500;
	localparam int unsigned WDOG_LIMIT     = 4000;
	localparam int unsigned TAIL_CYCLES    = 120;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	pfe_item_t item;
	logic      enc_valid;
	logic      enc_stall;
	pfe_out_t  enc;

	wire_byte_predictor predictor = new();
	int unsigned        commands_sent;
	int unsigned        idle_cycles;

	protobuf_field_emitter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.enc_valid  (enc_valid),
		.enc_stall  (enc_stall),
		.enc        (enc)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic pfe_item_t make_cmd(logic [2:0] m, logic [28:0] f, logic [63:0] v);
		pfe_item_t it;
		it.mode = m;
		it.field_number = f;
		it.value = v;
		return it;
	endfunction

	// Random value no wider than max_bits; the width itself is random.
	function automatic logic [63:0] rand_value(int unsigned max_bits);
		int unsigned nbits;
		logic [63:0] v;
		nbits = $urandom_range(0, max_bits);
		v = {$urandom, $urandom};
		if (nbits < 64) begin
			v = v & ((64'd1 << nbits) - 64'd1);
		end
		return v;
	endfunction

	function automatic logic [28:0] rand_field();
		case ($urandom_range(0, 3))
			0: return 29'($urandom_range(0, 15));
			1: return 29'($urandom_range(16, 2047));
			default: return 29'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_cmd(input pfe_item_t it);
		int unsigned gap;
		@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predictor.take_command(it);
		if (it.mode <= MODE_CLOSE) commands_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold the input side until every predicted byte has come out.
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (predictor.pending() != 0) @(negedge clk);
	endtask

	task automatic run_directed();
		// field zero, all-ones field and value, varint boundary at 128
		send_cmd(make_cmd(MODE_VARINT, '0, '0));
		send_cmd(make_cmd(MODE_VARINT, '1, '1));
		send_cmd(make_cmd(MODE_VARINT, 29'd1, 64'd128));
		send_cmd(make_cmd(MODE_LENHDR, 29'd15, 64'd300));
		send_cmd(make_cmd(MODE_LENHDR, '1, '0));
		send_cmd(make_cmd(MODE_PAYLOAD, '1, '1));
		send_cmd(make_cmd(MODE_PAYLOAD, '0, '0));
		send_cmd(make_cmd(MODE_UNUSED_LO, '1, '1));
		send_cmd(make_cmd(MODE_UNUSED_HI, '0, '0));
		// empty packed close
		send_cmd(make_cmd(MODE_CLOSE, '0, '0));
		// fill the buffer exactly: four 10-byte varints and one 8-byte varint
		repeat (4) send_cmd(make_cmd(MODE_PACKED, '0, '1));
		send_cmd(make_cmd(MODE_PACKED, '1, 64'd1 << 49));
		send_cmd(make_cmd(MODE_CLOSE, '1, '0));
		// overflow on the fifth element, drop the next, then close with error
		repeat (5) send_cmd(make_cmd(MODE_PACKED, '0, '1));
		send_cmd(make_cmd(MODE_PACKED, '0, '0));
		send_cmd(make_cmd(MODE_CLOSE, 29'd7, '0));
		wait_drained();
	endtask

	task automatic run_random();
		int unsigned pick;
		int unsigned n;
		bit          paused;
		paused = 1'b0;
		commands_sent = 0;
		while (commands_sent < RAND_COMMANDS) begin
			if (!paused && commands_sent >= PAUSE_AT) begin
				paused = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				// packed run that always fits
				n = $urandom_range(0, 8);
				repeat (n) send_cmd(make_cmd(MODE_PACKED, rand_field(), rand_value(21)));
				send_cmd(make_cmd(MODE_CLOSE, rand_field(), rand_value(64)));
			end else if (pick < 40) begin
				// packed run likely to overflow
				n = $urandom_range(4, 10);
				repeat (n) send_cmd(make_cmd(MODE_PACKED, rand_field(), rand_value(64)));
				send_cmd(make_cmd(MODE_CLOSE, rand_field(), rand_value(64)));
			end else if (pick < 60) begin
				// length header followed by its payload
				n = $urandom_range(0, 6);
				send_cmd(make_cmd(MODE_LENHDR, rand_field(), 64'(n)));
				repeat (n) send_cmd(make_cmd(MODE_PAYLOAD, rand_field(), rand_value(64)));
			end else if (pick < 85) begin
				send_cmd(make_cmd(MODE_VARINT, rand_field(), rand_value(64)));
			end else if (pick < 90) begin
				send_cmd(make_cmd(MODE_LENHDR, rand_field(), rand_value(64)));
			end else if (pick < 96) begin
				send_cmd(make_cmd(MODE_PAYLOAD, rand_field(), rand_value(64)));
			end else begin
				send_cmd(make_cmd(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
					rand_field(), rand_value(64)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		commands_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		run_random();
		@(negedge clk);
		item_valid <= 1'b0;
		while (predictor.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (predictor.mismatches == 0) begin
			$display("PASS protobuf_field_emitter");
		end else begin
			$display("FAIL protobuf_field_emitter");
		end
		$finish;
	end

	// Output side: random stalls, plus one long hold-off to back up the input.
	initial begin
		int unsigned r;
		int unsigned run;
		logic        stall_level;
		bit          held;
		enc_stall = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && predictor.bytes_seen >= HOLD_AFTER) begin
				held = 1'b1;
				@(negedge clk);
				enc_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				stall_level = 1'b0;
				run = $urandom_range(1, 24);
			end else if (r < 92) begin
				stall_level = 1'b1;
				run = $urandom_range(1, 3);
			end else begin
				stall_level = 1'b1;
				run = $urandom_range(8, 40);
			end
			repeat (run) begin
				@(negedge clk);
				enc_stall <= stall_level;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && enc_valid && !enc_stall) begin
			predictor.check_byte(enc);
		end
	end

	// End the run if neither channel moves a transaction for too long.
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (enc_valid && !enc_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WDOG_LIMIT) begin
				$display("FAIL protobuf_field_emitter");
				$finish;
			end
		end
	end
endmodule
